/* hw/rtl/bpg_pkg.sv */
// Shared types, constants and codes for the Bezier patch point index generator.
// Used by bpg_cfg, bpg_ctrl, bpg_dp and the top level.
`timescale 1ns / 1ps

package bpg_pkg;

  // Default sizing of the multiplicity table and degree clamp
  localparam int DEF_MAX_DIMS   = 3;
  localparam int DEF_MAX_KNOTS  = 64;
  localparam int DEF_MAX_DEGREE = 3;

  // Field widths
  localparam int AXES      = 3;   // dimensions that have registers
  localparam int DIM_W     = 2;
  localparam int DEG_W     = 2;
  localparam int KNOT_W    = 7;
  localparam int SLOT_W    = 6;
  localparam int MULT_W    = 4;
  localparam int PATCH_W   = 18;
  localparam int PID_W     = 24;
  localparam int LPOS_W    = 6;
  localparam int TOT_W     = 21;  // product of three patch counts of at most 126
  localparam int SUM_W     = 11;  // sum of at most 127 multiplicities of 4 bits
  localparam int DCNT_W    = 5;
  localparam int CIDX_W    = 3;
  localparam int CDATA_W   = 7;

  // Command codes of an input transaction
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_DIMS_USED = 3'd0;
  localparam logic [CIDX_W-1:0] REG_DEGREE_U  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_DEGREE_V  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_DEGREE_W  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_KNOTS_U   = 3'd4;
  localparam logic [CIDX_W-1:0] REG_KNOTS_V   = 3'd5;
  localparam logic [CIDX_W-1:0] REG_KNOTS_W   = 3'd6;

  typedef struct packed {
    logic                cmd;
    logic [DIM_W-1:0]    dim_select;
    logic [SLOT_W-1:0]   knot_slot;
    logic [MULT_W-1:0]   multiplicity;
    logic [PATCH_W-1:0]  patch_number;
  } item_t;

  typedef struct packed {
    logic [PID_W-1:0]    point_id;
    logic [LPOS_W-1:0]   local_position;
    logic                last;
    logic                bad_patch;
  } result_t;

  // Clamped configuration as the datapath sees it
  typedef struct packed {
    logic [DIM_W-1:0]              nd;
    logic [AXES-1:0][DEG_W-1:0]    deg;
    logic [AXES-1:0][KNOT_W-1:0]   np;   // patch count per dimension
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic req;
    logic tot_step;
    logic div_start;
    logic div_step;
    logic scan_start;
    logic scale;
    logic base;
    logic emit;
    logic bad_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic dim_last;
    logic div_done;
    logic scan_done;
    logic bad;
    logic out_free;
    logic emit_last;
  } status_t;

endpackage

/* hw/rtl/bpg_cfg.sv */
// Configuration registers, stored already clamped into their legal ranges.
// Depends on bpg_pkg.
`timescale 1ns / 1ps

module bpg_cfg #(
  parameter int MAX_DIMS   = bpg_pkg::DEF_MAX_DIMS,
  parameter int MAX_KNOTS  = bpg_pkg::DEF_MAX_KNOTS,
  parameter int MAX_DEGREE = bpg_pkg::DEF_MAX_DEGREE
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bpg_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [bpg_pkg::CDATA_W-1:0]  cfg_data,
  output bpg_pkg::cfg_t                cfg
);
  import bpg_pkg::*;

  logic [DIM_W-1:0]  nd_clamped;
  logic [DEG_W-1:0]  deg_clamped;
  logic [KNOT_W-1:0] np_clamped;
  logic [DIM_W-1:0]  dims_raw;
  logic [KNOT_W-1:0] knots_raw;

  assign cfg_ready = 1'b1;
  assign dims_raw  = cfg_data[DIM_W-1:0];
  assign knots_raw = cfg_data[KNOT_W-1:0];

  // Clamp the written value for each kind of register
  always_comb begin
    if (dims_raw == '0) begin
      nd_clamped = DIM_W'(1);
    end else if (int'(dims_raw) > MAX_DIMS) begin
      nd_clamped = DIM_W'(MAX_DIMS);
    end else begin
      nd_clamped = dims_raw;
    end
    if (int'(cfg_data[DEG_W-1:0]) > MAX_DEGREE) begin
      deg_clamped = DEG_W'(MAX_DEGREE);
    end else begin
      deg_clamped = cfg_data[DEG_W-1:0];
    end
    if (knots_raw < KNOT_W'(2)) begin
      np_clamped = KNOT_W'(1);
    end else if (int'(knots_raw) > MAX_KNOTS) begin
      np_clamped = KNOT_W'(MAX_KNOTS - 1);
    end else begin
      np_clamped = knots_raw - KNOT_W'(1);
    end
  end

  // Hold the registers, update on a write transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nd <= DIM_W'(1);
      for (int j = 0; j < AXES; j++) begin
        cfg.deg[j] <= DEG_W'(1);
        cfg.np[j]  <= KNOT_W'(1);
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DIMS_USED: cfg.nd     <= nd_clamped;
        REG_DEGREE_U:  cfg.deg[0] <= deg_clamped;
        REG_DEGREE_V:  cfg.deg[1] <= deg_clamped;
        REG_DEGREE_W:  cfg.deg[2] <= deg_clamped;
        REG_KNOTS_U:   cfg.np[0]  <= np_clamped;
        REG_KNOTS_V:   cfg.np[1]  <= np_clamped;
        REG_KNOTS_W:   cfg.np[2]  <= np_clamped;
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/bpg_ctrl.sv */
// Controller state machine: sequences load, patch count check, per-dimension
// divide, table scan and scaling, then point emission. Depends on bpg_pkg.
`timescale 1ns / 1ps

module bpg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              item_cmd,
  input  bpg_pkg::status_t  status,
  output bpg_pkg::cmd_t     cmd
);
  import bpg_pkg::*;

  typedef enum logic [3:0] {
    IDLE,
    TOTAL,
    CHECK,
    DIVIDE,
    SCAN,
    SCALE,
    BASE,
    EMIT,
    BAD
  } state_t;

  state_t state;
  state_t state_next;

  assign item_stall = (state != IDLE);

  // Decode commands and the next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (item_valid) begin
          if (item_cmd == CMD_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.req    = 1'b1;
            state_next = TOTAL;
          end
        end
      end
      TOTAL: begin
        cmd.tot_step = 1'b1;
        if (status.dim_last) begin
          state_next = CHECK;
        end
      end
      CHECK: begin
        if (status.bad) begin
          state_next = BAD;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = DIVIDE;
        end
      end
      DIVIDE: begin
        if (status.div_done) begin
          cmd.scan_start = 1'b1;
          state_next     = SCAN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      SCAN: begin
        if (status.scan_done) begin
          state_next = SCALE;
        end
      end
      SCALE: begin
        cmd.scale  = 1'b1;
        state_next = BASE;
      end
      BASE: begin
        cmd.base = 1'b1;
        if (status.dim_last) begin
          state_next = EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = DIVIDE;
        end
      end
      EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.emit_last) begin
            state_next = IDLE;
          end
        end
      end
      BAD: begin
        if (status.out_free) begin
          cmd.bad_out = 1'b1;
          state_next  = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/bpg_dp.sv */
// Datapath: multiplicity memory, restoring divider, prefix-sum scan, stride
// and offset products, point counters and the result register. Depends on bpg_pkg.
`timescale 1ns / 1ps

module bpg_dp #(
  parameter int MAX_DIMS  = bpg_pkg::DEF_MAX_DIMS,
  parameter int MAX_KNOTS = bpg_pkg::DEF_MAX_KNOTS
) (
  input  logic              clk,
  input  logic              rst,
  input  bpg_pkg::item_t    item,
  input  bpg_pkg::cfg_t     cfg,
  input  bpg_pkg::cmd_t     cmd,
  output bpg_pkg::status_t  status,
  output logic              result_valid,
  input  logic              result_stall,
  output bpg_pkg::result_t  result
);
  import bpg_pkg::*;

  localparam int DEPTH = MAX_DIMS * MAX_KNOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Multiplicity memory
  logic [MULT_W-1:0] mem [DEPTH];
  logic [MULT_W-1:0] rd_data;
  logic              load_ok;
  logic [AW-1:0]     load_addr;
  logic [AW-1:0]     scan_addr;

  // Request state
  logic [PATCH_W-1:0] patch;
  logic [PATCH_W-1:0] rem;
  logic [TOT_W-1:0]   total;
  logic [DIM_W-1:0]   d;
  logic [DEG_W-1:0]   deg_sel;
  logic [KNOT_W-1:0]  np_sel;

  // Divider
  logic [PATCH_W-1:0] div_q;
  logic [KNOT_W-1:0]  div_r;
  logic [DCNT_W-1:0]  div_cnt;
  logic [KNOT_W:0]    div_shift;
  logic               div_ge;

  // Scan
  logic               issuing;
  logic               rd_v;
  logic [KNOT_W-1:0]  k;
  logic [KNOT_W-1:0]  rd_k;
  logic [KNOT_W-1:0]  coord;
  logic [SUM_W-1:0]   res_sum;
  logic [SUM_W-1:0]   off_sum;

  // Strides and emission
  logic [PID_W-1:0]   stride;
  logic [PID_W-1:0]   str_cur;
  logic [PID_W-1:0]   res_val;
  logic [PID_W-1:0]   base_val;
  logic [PID_W-1:0]   str   [MAX_DIMS];
  logic [PID_W-1:0]   base  [MAX_DIMS];
  logic [PID_W-1:0]   acc   [MAX_DIMS];
  logic [PID_W-1:0]   acc_next [MAX_DIMS];
  logic [DEG_W-1:0]   lpos  [MAX_DIMS];
  logic [DEG_W-1:0]   lpos_next [MAX_DIMS];
  logic [LPOS_W-1:0]  pos;
  logic [PID_W-1:0]   pid_sum;
  logic               emit_last;
  logic               carry;

  assign deg_sel = cfg.deg[d];
  assign np_sel  = cfg.np[d];

  assign load_ok   = (int'(item.dim_select) < MAX_DIMS) && (int'(item.knot_slot) < MAX_KNOTS);
  assign load_addr = AW'(int'(item.dim_select) * MAX_KNOTS + int'(item.knot_slot));
  assign scan_addr = AW'(int'(d) * MAX_KNOTS + int'(k));

  // Restoring divide step: one quotient bit a cycle
  assign div_shift = {div_r, div_q[PATCH_W-1]};
  assign div_ge    = (div_shift >= {1'b0, np_sel});

  assign res_val  = PID_W'(res_sum) - PID_W'(deg_sel) - PID_W'(1);
  assign base_val = PID_W'(PID_W'(off_sum) * str_cur);

  // Advance the local point counters, dimension 0 fastest
  always_comb begin
    carry     = 1'b1;
    emit_last = 1'b1;
    pid_sum   = '0;
    for (int j = 0; j < MAX_DIMS; j++) begin
      lpos_next[j] = lpos[j];
      acc_next[j]  = acc[j];
      pid_sum      = pid_sum + acc[j];
      if (j < int'(cfg.nd)) begin
        if (lpos[j] != cfg.deg[j]) begin
          emit_last = 1'b0;
        end
        if (carry) begin
          if (lpos[j] == cfg.deg[j]) begin
            lpos_next[j] = '0;
            acc_next[j]  = base[j];
          end else begin
            lpos_next[j] = lpos[j] + DEG_W'(1);
            acc_next[j]  = acc[j] + str[j];
            carry        = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    status.dim_last  = (d == cfg.nd - DIM_W'(1));
    status.div_done  = (div_cnt == DCNT_W'(PATCH_W));
    status.scan_done = !issuing && !rd_v;
    status.bad       = (TOT_W'(patch) >= total);
    status.out_free  = !result_valid || !result_stall;
    status.emit_last = emit_last;
  end

  // Write loads, read during the scan
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      mem[load_addr] <= item.multiplicity;
    end
    if (issuing) begin
      rd_data <= mem[scan_addr];
    end
  end

  // Control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing      <= 1'b0;
      rd_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_v <= issuing;
      if (cmd.scan_start) begin
        issuing <= 1'b1;
      end else if (issuing && k == np_sel) begin
        issuing <= 1'b0;
      end
      if (cmd.emit || cmd.bad_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.req) begin
      patch  <= item.patch_number;
      rem    <= item.patch_number;
      total  <= TOT_W'(1);
      stride <= PID_W'(1);
      d      <= '0;
      pos    <= '0;
      for (int j = 0; j < MAX_DIMS; j++) begin
        lpos[j] <= '0;
        str[j]  <= '0;
        base[j] <= '0;
        acc[j]  <= '0;
      end
    end
    if (cmd.tot_step) begin
      total <= TOT_W'(total * TOT_W'(np_sel));
      d     <= status.dim_last ? '0 : d + DIM_W'(1);
    end
    if (cmd.div_start) begin
      div_q   <= rem;
      div_r   <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      div_r   <= div_ge ? KNOT_W'(div_shift - {1'b0, np_sel}) : div_shift[KNOT_W-1:0];
      div_q   <= {div_q[PATCH_W-2:0], div_ge};
      div_cnt <= div_cnt + DCNT_W'(1);
    end
    // Scan slots 0..np: total for resolution, slots 1..coord for offset
    if (cmd.scan_start) begin
      coord   <= div_r;
      rem     <= div_q;
      k       <= '0;
      res_sum <= '0;
      off_sum <= '0;
    end
    if (issuing) begin
      k    <= k + KNOT_W'(1);
      rd_k <= k;
    end
    if (rd_v) begin
      res_sum <= res_sum + SUM_W'(rd_data);
      if (rd_k != '0 && rd_k <= coord) begin
        off_sum <= off_sum + SUM_W'(rd_data);
      end
    end
    if (cmd.scale) begin
      str_cur <= stride;
      stride  <= PID_W'(stride * res_val);
    end
    if (cmd.base) begin
      for (int j = 0; j < MAX_DIMS; j++) begin
        if (d == DIM_W'(j)) begin
          str[j]  <= str_cur;
          base[j] <= base_val;
          acc[j]  <= base_val;
        end
      end
      d <= d + DIM_W'(1);
    end
    // Load the result register
    if (cmd.emit) begin
      result.point_id       <= pid_sum;
      result.local_position <= pos;
      result.last           <= emit_last;
      result.bad_patch      <= 1'b0;
      pos                   <= pos + LPOS_W'(1);
      for (int j = 0; j < MAX_DIMS; j++) begin
        lpos[j] <= lpos_next[j];
        acc[j]  <= acc_next[j];
      end
    end
    if (cmd.bad_out) begin
      result.point_id       <= '0;
      result.local_position <= '0;
      result.last           <= 1'b1;
      result.bad_patch      <= 1'b1;
    end
  end

endmodule

/* hw/rtl/bezier_patch_point_index_generator.sv */
// Bezier patch point index generator. A load transaction writes the
// multiplicity table. A request forms the patch count, then per dimension runs the
// bit-serial divider, the table scan and the scale and base steps. It then emits
// one point per cycle unless stalled, the product of (degree+1) over dimensions.
// Reset (synchronous, rst high) clears control and restores register defaults;
// the multiplicity table is not cleared and must be loaded before use.
`timescale 1ns / 1ps

module bezier_patch_point_index_generator #(
  parameter int MAX_DIMS   = bpg_pkg::DEF_MAX_DIMS,
  parameter int MAX_KNOTS  = bpg_pkg::DEF_MAX_KNOTS,
  parameter int MAX_DEGREE = bpg_pkg::DEF_MAX_DEGREE
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  bpg_pkg::item_t               item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output bpg_pkg::result_t             result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bpg_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [bpg_pkg::CDATA_W-1:0]  cfg_data
);
  import bpg_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  bpg_cfg #(
    .MAX_DIMS   (MAX_DIMS),
    .MAX_KNOTS  (MAX_KNOTS),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_cmd   (item.cmd),
    .status     (status),
    .cmd        (cmd)
  );

  bpg_dp #(
    .MAX_DIMS  (MAX_DIMS),
    .MAX_KNOTS (MAX_KNOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* tb/sv/bezier_patch_point_index_generator_tb.sv */
// Self-checking testbench for bezier_patch_point_index_generator: loads knot
// multiplicities, requests patches and checks every emitted point index.
// Depends on bpg_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module bezier_patch_point_index_generator_tb;
  import bpg_pkg::*;

  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 300;
  localparam int POINT_LIMIT   = 64;
  localparam int PATCH_MAX     = (1 << PATCH_W) - 1;
  localparam logic [CIDX_W-1:0] REG_SPARE = 3'd7;   // index with no register behind it

  // Expected point stream of the generator, kept in step with accepted transactions
  class patch_point_board;
    logic [MULT_W-1:0] mult_tab [AXES][DEF_MAX_KNOTS];
    logic [DIM_W-1:0]  dims_reg = 2'd1;
    logic [DEG_W-1:0]  deg_reg [AXES] = '{default: 2'd1};
    logic [KNOT_W-1:0] knots_reg [AXES] = '{default: 7'd2};
    result_t           pending_points[$];
    int unsigned       failures, requests, bad_requests, loads, points, reg_writes;

    // A 2-bit field never exceeds three axes, so only zero needs clamping
    function int unsigned axes_used();
      return (dims_reg == 0) ? 1 : dims_reg;
    endfunction

    function longint unsigned patch_span(int unsigned d);
      if (knots_reg[d] < 2) return 1;
      if (knots_reg[d] > DEF_MAX_KNOTS) return DEF_MAX_KNOTS - 1;
      return knots_reg[d] - 1;
    endfunction

    function longint unsigned patch_total();
      longint unsigned t;
      t = 1;
      for (int unsigned d = 0; d < axes_used(); d++) t = t * patch_span(d);
      return t;
    endfunction

    // Append one expected point at the tail of the queue
    function void queue_point(result_t p);
      pending_points = {pending_points, p};
    endfunction

    function void set_register(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_DIMS_USED: dims_reg = data[DIM_W-1:0];
        REG_DEGREE_U:  deg_reg[0] = data[DEG_W-1:0];
        REG_DEGREE_V:  deg_reg[1] = data[DEG_W-1:0];
        REG_DEGREE_W:  deg_reg[2] = data[DEG_W-1:0];
        REG_KNOTS_U:   knots_reg[0] = data;
        REG_KNOTS_V:   knots_reg[1] = data;
        REG_KNOTS_W:   knots_reg[2] = data;
        default: ;
      endcase
    endfunction

    // Note an accepted transaction and queue the points it must produce
    function void accept_item(item_t it);
      longint unsigned total, rem, stride, res, id, loc, r, np, c, npts, count, radix;
      longint unsigned off [AXES];
      longint unsigned str [AXES];
      int unsigned     nd;
      result_t         exp;
      if (it.cmd == CMD_LOAD) begin
        if (it.dim_select < AXES) mult_tab[it.dim_select][it.knot_slot] = it.multiplicity;
        loads++;
        return;
      end
      requests++;
      nd = axes_used();
      total = patch_total();
      if (it.patch_number >= total) begin
        exp.point_id = '0;
        exp.local_position = '0;
        exp.last = 1'b1;
        exp.bad_patch = 1'b1;
        queue_point(exp);
        bad_requests++;
        return;
      end
      // split the patch number and build offsets and strides, wrapping at 64 bits
      rem = it.patch_number;
      stride = 1;
      npts = 1;
      for (int unsigned d = 0; d < nd; d++) begin
        np = patch_span(d);
        c = rem % np;
        rem = rem / np;
        off[d] = 0;
        for (longint unsigned k = 1; k <= c; k++) off[d] += mult_tab[d][k];
        res = 0;
        for (longint unsigned k = 0; k <= np; k++) res += mult_tab[d][k];
        str[d] = stride;
        radix = deg_reg[d];
        stride = stride * (res - radix - 1);
        npts = npts * (radix + 1);
      end
      count = (npts > POINT_LIMIT) ? POINT_LIMIT : npts;
      // walk local points, dimension 0 fastest
      for (longint unsigned i = 0; i < count; i++) begin
        r = i;
        id = 0;
        for (int unsigned d = 0; d < nd; d++) begin
          radix = deg_reg[d];
          radix = radix + 1;
          loc = r % radix;
          r = r / radix;
          id += (loc + off[d]) * str[d];
        end
        exp.point_id = id[PID_W-1:0];
        exp.local_position = i[LPOS_W-1:0];
        exp.last = (i + 1 == count);
        exp.bad_patch = 1'b0;
        queue_point(exp);
      end
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_point(result_t got);
      result_t exp;
      points++;
      if (pending_points.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected point: id=%0h pos=%0d last=%0b bad=%0b",
                   got.point_id, got.local_position, got.last, got.bad_patch);
        return;
      end
      exp = pending_points.pop_front();
      if (got.point_id !== exp.point_id || got.local_position !== exp.local_position ||
          got.last !== exp.last || got.bad_patch !== exp.bad_patch) begin
        failures++;
        if (failures <= 10) begin
          $write("point mismatch: expected id=%0h pos=%0d last=%0b bad=%0b",
                 exp.point_id, exp.local_position, exp.last, exp.bad_patch);
          $display(", got id=%0h pos=%0d last=%0b bad=%0b",
                   got.point_id, got.local_position, got.last, got.bad_patch);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_stall;
  item_t               item;
  logic                result_valid;
  logic                result_stall;
  result_t             result;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index;
  logic [CDATA_W-1:0]  cfg_data;

  patch_point_board board;
  bit               quiet_mode;
  int               stall_left;
  int               cycle_count;

  bezier_patch_point_index_generator u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d points outstanding",
               cycle_count, board.pending_points.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Observe both handshakes on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) board.accept_item(item);
      if (result_valid && !result_stall) board.check_point(result);
    end
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int gap_cycles();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CDATA_W-1:0] pick_knots();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return CDATA_W'($urandom_range(2, 8));
    if (r < 75) return CDATA_W'(DEF_MAX_KNOTS);
    if (r < 85) return CDATA_W'($urandom_range(0, 1));
    if (r < 92) return CDATA_W'($urandom_range(65, 127));
    return CDATA_W'($urandom_range(9, 63));
  endfunction

  // Stall the result side at random
  always @(negedge clk) begin
    if (stall_left == 0 && !rst && !quiet_mode && $urandom_range(0, 2) == 0)
      stall_left = gap_cycles();
    result_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // Present one transaction and hold it until taken; valid stays high on return
  task automatic send_item(input item_t it);
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_load(input logic [DIM_W-1:0] d, input logic [SLOT_W-1:0] s,
                           input logic [MULT_W-1:0] m);
    item_t it;
    it.cmd = CMD_LOAD;
    it.dim_select = d;
    it.knot_slot = s;
    it.multiplicity = m;
    it.patch_number = PATCH_W'($urandom_range(0, PATCH_MAX));
    send_item(it);
  endtask

  task automatic send_request(input logic [PATCH_W-1:0] pn);
    item_t it;
    it.cmd = CMD_REQUEST;
    it.dim_select = DIM_W'($urandom_range(0, 3));
    it.knot_slot = SLOT_W'($urandom_range(0, 63));
    it.multiplicity = MULT_W'($urandom_range(0, 15));
    it.patch_number = pn;
    send_item(it);
  endtask

  // Drop valid, wait for every expected point, then let the block settle
  task automatic drain();
    item_valid <= 1'b0;
    while (board.pending_points.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_register(idx, data);
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [CDATA_W-1:0] dims, du, dv, dw, ku, kv, kw);
    drain();
    write_reg(REG_SPARE, CDATA_W'($urandom_range(0, 127)));
    write_reg(REG_DIMS_USED, dims);
    write_reg(REG_DEGREE_U, du);
    write_reg(REG_DEGREE_V, dv);
    write_reg(REG_DEGREE_W, dw);
    write_reg(REG_KNOTS_U, ku);
    write_reg(REG_KNOTS_V, kv);
    write_reg(REG_KNOTS_W, kw);
    cfg_valid <= 1'b0;
  endtask

  // Random mix: mostly in-range requests, some loads and out-of-range patches
  task automatic run_phase(input int n);
    for (int i = 0; i < n; i++) begin
      int gap;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25)
        send_load(DIM_W'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, 63)),
                  MULT_W'($urandom_range(0, 15)));
      else if (pick < 37)
        send_request(PATCH_W'($urandom_range(PATCH_MAX, int'(board.patch_total()))));
      else
        send_request(PATCH_W'($urandom_range(0, int'(board.patch_total()) - 1)));
      if (i == n / 2 || $urandom_range(0, 49) == 0) begin
        drain();
      end else begin
        gap = (quiet_mode || $urandom_range(0, 1) == 0) ? 0 : gap_cycles();
        if (gap > 0) begin
          item_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  endtask

  initial begin
    board = new;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet_mode = 1'b1;
    stall_left = 0;
    cycle_count = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fill the whole table so no request reads an unwritten entry
    for (int d = 0; d < AXES; d++)
      for (int s = 0; s < DEF_MAX_KNOTS; s++)
        send_load(DIM_W'(d), SLOT_W'(s), MULT_W'($urandom_range(0, 15)));

    // Reset settings: one patch, out-of-range patches, ignored load, fresh value
    send_request('0);
    send_request(PATCH_W'(1));
    send_request(PATCH_W'(PATCH_MAX));
    send_load(2'd3, 6'd5, 4'd15);
    send_load(2'd0, 6'd1, 4'd15);
    send_request('0);

    // Largest mesh: three axes, degree 3, 64 knots each
    apply_settings(7'd3, 7'd3, 7'd3, 7'd3, 7'd64, 7'd64, 7'd64);
    send_request('0);
    send_request(PATCH_W'(250046));
    send_request(PATCH_W'(250047));
    send_request(PATCH_W'(123457));

    // Zero axis count and oversized knot count clamp; degree 0 gives one point
    apply_settings(7'h7C, 7'h7C, 7'd2, 7'd1, 7'd127, 7'd2, 7'd2);
    send_request(PATCH_W'(62));
    send_request(PATCH_W'(63));
    send_request('0);

    // Undersized knot counts and a negative resolution that wraps
    apply_settings(7'd2, 7'd3, 7'd3, 7'd1, 7'd0, 7'd1, 7'd100);
    for (int d = 0; d < 2; d++)
      for (int s = 0; s < 3; s++)
        send_load(DIM_W'(d), SLOT_W'(s), '0);
    send_request('0);

    // Random phases, each under fresh settings
    for (int p = 0; p < 9; p++) begin
      quiet_mode = (p == 4);
      apply_settings(CDATA_W'($urandom_range(0, 127)), CDATA_W'($urandom_range(0, 127)),
                     CDATA_W'($urandom_range(0, 127)), CDATA_W'($urandom_range(0, 127)),
                     pick_knots(), pick_knots(), pick_knots());
      run_phase(28);
    end
    quiet_mode = 1'b0;
    drain();

    if (board.pending_points.size() != 0) begin
      board.failures++;
      $display("%0d expected points never arrived", board.pending_points.size());
    end
    $display("run covered %0d requests (%0d out of range), %0d table loads, %0d register writes",
             board.requests, board.bad_requests, board.loads, board.reg_writes);
    $display("checked %0d points in %0d cycles, %0d failures",
             board.points, cycle_count, board.failures);
    if (board.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/bpg_pkg.sv
hw/rtl/bpg_cfg.sv
hw/rtl/bpg_ctrl.sv
hw/rtl/bpg_dp.sv
hw/rtl/bezier_patch_point_index_generator.sv
tb/sv/bezier_patch_point_index_generator_tb.sv
